/* rtl/macd_pkg.sv */
// shared widths, types, register indexes and saturation helper for the macd block
package macd_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int COEF_WIDTH = 16;
	localparam int DIFF_WIDTH = DATA_WIDTH + 1;
	localparam int PROD_WIDTH = DIFF_WIDTH + COEF_WIDTH + 1;
	localparam int SUM_WIDTH  = DATA_WIDTH + 2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic        [COEF_WIDTH-1:0] coef_t;
	typedef logic signed [DIFF_WIDTH-1:0] diff_t;
	typedef logic signed [PROD_WIDTH-1:0] prod_t;
	typedef logic signed [SUM_WIDTH-1:0]  sum_t;
	typedef logic        [1:0]            reg_idx_t;

	// configuration register indexes
	localparam reg_idx_t REG_SHORT_ALPHA  = 2'd0;
	localparam reg_idx_t REG_LONG_ALPHA   = 2'd1;
	localparam reg_idx_t REG_SIGNAL_ALPHA = 2'd2;

	// reset values of the smoothing factors
	localparam coef_t SHORT_ALPHA_RST  = COEF_WIDTH'(10082);
	localparam coef_t LONG_ALPHA_RST   = COEF_WIDTH'(4855);
	localparam coef_t SIGNAL_ALPHA_RST = COEF_WIDTH'(13107);

	// which average the shared datapath works on
	typedef enum logic [1:0] {
		EMA_SHORT  = 2'd0,
		EMA_LONG   = 2'd1,
		EMA_SIGNAL = 2'd2
	} ema_sel_t;

	// controller to datapath command word
	typedef struct packed {
		logic     take_x;
		logic     first;
		logic     diff;
		logic     mul;
		logic     acc;
		logic     macd;
		logic     finish;
		ema_sel_t sel;
	} cmd_t;

	// one result item
	typedef struct packed {
		data_t short_ema;
		data_t long_ema;
		data_t macd_value;
		data_t signal_value;
		data_t histogram;
	} res_t;

	// clamp a widened sum to the signed data range
	function automatic data_t sat(input sum_t v);
		logic [SUM_WIDTH-DATA_WIDTH:0] top;
		data_t                         r;
		top = v[SUM_WIDTH-1:DATA_WIDTH-1];
		if ((&top) || !(|top)) begin
			r = v[DATA_WIDTH-1:0];
		end else if (v[SUM_WIDTH-1]) begin
			r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

	// sign-extend a data word to sum width
	function automatic sum_t ext(input data_t v);
		return {{(SUM_WIDTH-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
	endfunction

endpackage

/* rtl/macd_if.sv */
// handshake channel interfaces for price items, result items and register writes
interface macd_in_if;
	logic               valid;
	logic               ready;
	macd_pkg::data_t    price;

	modport source (output valid, output price, input ready);
	modport sink   (input valid, input price, output ready);
endinterface

interface macd_out_if;
	logic               valid;
	logic               ready;
	macd_pkg::data_t    short_ema;
	macd_pkg::data_t    long_ema;
	macd_pkg::data_t    macd_value;
	macd_pkg::data_t    signal_value;
	macd_pkg::data_t    histogram;

	modport source (output valid, output short_ema, output long_ema, output macd_value,
		output signal_value, output histogram, input ready);
	modport sink   (input valid, input short_ema, input long_ema, input macd_value,
		input signal_value, input histogram, output ready);
endinterface

interface macd_cfg_if;
	logic               valid;
	logic               ready;
	macd_pkg::reg_idx_t index;
	macd_pkg::coef_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/macd_ctrl.sv */
// sequencing state machine: walks the shared ema datapath through one item
module macd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output macd_pkg::cmd_t cmd
);
	import macd_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FIRST = 7'b0000010,
		S_DIFF  = 7'b0000100,
		S_MUL   = 7'b0001000,
		S_ACC   = 7'b0010000,
		S_MACD  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t   state_q, state_d;
	ema_sel_t sel_q, sel_d;
	logic     started_q, started_d;
	logic     out_valid_q, out_valid_d;

	// next state and command decode
	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		started_d   = started_q;
		out_valid_d = out_valid_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.sel     = sel_q;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_x = 1'b1;
					sel_d      = EMA_SHORT;
					state_d    = started_q ? S_DIFF : S_FIRST;
				end
			end
			S_FIRST: begin
				cmd.first = 1'b1;
				started_d = 1'b1;
				state_d   = S_DONE;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				case (sel_q)
					EMA_SHORT: begin
						sel_d   = EMA_LONG;
						state_d = S_DIFF;
					end
					EMA_LONG: begin
						state_d = S_MACD;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_MACD: begin
				cmd.macd = 1'b1;
				sel_d    = EMA_SIGNAL;
				state_d  = S_DIFF;
			end
			S_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= EMA_SHORT;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sel_q       <= sel_d;
			started_q   <= started_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/macd_dp.sv */
// datapath: averages, smoothing factors, shared subtract/multiply/accumulate, output register
module macd_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  macd_pkg::cmd_t     cmd,
	input  logic               cfg_we,
	input  macd_pkg::reg_idx_t cfg_idx,
	input  macd_pkg::coef_t    cfg_data,
	input  macd_pkg::data_t    price,
	output macd_pkg::res_t     res
);
	import macd_pkg::*;

	coef_t short_alpha_q, long_alpha_q, signal_alpha_q;
	data_t x_q, short_q, long_q, signal_q, macd_q;
	diff_t diff_q;
	prod_t prod_q;
	res_t  res_q;

	data_t cur_avg, cur_x;
	coef_t cur_alpha;
	prod_t prod_shift;
	sum_t  acc_sum;
	data_t acc_val;
	data_t macd_d;
	data_t hist_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_alpha_q  <= SHORT_ALPHA_RST;
			long_alpha_q   <= LONG_ALPHA_RST;
			signal_alpha_q <= SIGNAL_ALPHA_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SHORT_ALPHA:  short_alpha_q  <= cfg_data;
				REG_LONG_ALPHA:   long_alpha_q   <= cfg_data;
				REG_SIGNAL_ALPHA: signal_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand select for the average being updated
	always_comb begin
		case (cmd.sel)
			EMA_SHORT: begin
				cur_avg   = short_q;
				cur_x     = x_q;
				cur_alpha = short_alpha_q;
			end
			EMA_LONG: begin
				cur_avg   = long_q;
				cur_x     = x_q;
				cur_alpha = long_alpha_q;
			end
			default: begin
				cur_avg   = signal_q;
				cur_x     = macd_q;
				cur_alpha = signal_alpha_q;
			end
		endcase
	end

	// floor shift of the product, add to the average, clamp
	assign prod_shift = prod_q >>> COEF_WIDTH;
	assign acc_sum    = ext(cur_avg) + prod_shift[SUM_WIDTH-1:0];
	assign acc_val    = sat(acc_sum);
	assign macd_d     = sat(ext(short_q) - ext(long_q));
	assign hist_d     = sat(ext(macd_q) - ext(signal_q));

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.take_x) begin
			x_q <= price;
		end
		if (cmd.first) begin
			short_q  <= x_q;
			long_q   <= x_q;
			signal_q <= '0;
			macd_q   <= '0;
		end
		if (cmd.diff) begin
			diff_q <= {cur_x[DATA_WIDTH-1], cur_x} - {cur_avg[DATA_WIDTH-1], cur_avg};
		end
		if (cmd.mul) begin
			prod_q <= diff_q * $signed({1'b0, cur_alpha});
		end
		if (cmd.acc) begin
			case (cmd.sel)
				EMA_SHORT: short_q  <= acc_val;
				EMA_LONG:  long_q   <= acc_val;
				default:   signal_q <= acc_val;
			endcase
		end
		if (cmd.macd) begin
			macd_q <= macd_d;
		end
		if (cmd.finish) begin
			res_q.short_ema    <= short_q;
			res_q.long_ema     <= long_q;
			res_q.macd_value   <= macd_q;
			res_q.signal_value <= signal_q;
			res_q.histogram    <= hist_d;
		end
	end

	assign res = res_q;

endmodule

/* rtl/macd_ema_indicator.sv */
// top level of the macd indicator: controller, datapath and channel hookup
//
//  channel  dir  payload                                           accepted when
//  in_ch    in   price                                             valid & ready
//  out_ch   out  short_ema long_ema macd_value signal_value hist.  valid & ready
//  cfg      in   index, data (alpha register write)                valid & ready
//
// one item at a time; the first item after reset only seeds the averages, and every later
// item takes three subtract/multiply/accumulate passes through the single shared
// multiplier plus the macd and output steps.
// arst_n clears the controller, the started flag and loads the default alphas.
// a finished item sits in the output register while the next item is taken in;
// a stalled output holds the controller in its last step until the register frees.
module macd_ema_indicator (
	input  logic       clk,
	input  logic       arst_n,
	macd_in_if.sink    in_ch,
	macd_out_if.source out_ch,
	macd_cfg_if.sink   cfg
);
	import macd_pkg::*;

	cmd_t cmd;
	res_t res;

	// sequencer
	macd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	// arithmetic and storage
	macd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_we   (cfg.valid),
		.cfg_idx  (cfg.index),
		.cfg_data (cfg.data),
		.price    (in_ch.price),
		.res      (res)
	);

	// register writes are always taken
	assign cfg.ready = 1'b1;

	// result fields
	assign out_ch.short_ema    = res.short_ema;
	assign out_ch.long_ema     = res.long_ema;
	assign out_ch.macd_value   = res.macd_value;
	assign out_ch.signal_value = res.signal_value;
	assign out_ch.histogram    = res.histogram;

endmodule

/* rtl/macd_checker.sv */
// port-level checks for the macd indicator, bound to the top level
module macd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input macd_pkg::data_t short_ema,
	input macd_pkg::data_t long_ema,
	input macd_pkg::data_t macd_value,
	input macd_pkg::data_t signal_value,
	input macd_pkg::data_t histogram
);
	import macd_pkg::*;

	logic  seen_q;
	data_t macd_chk;
	data_t hist_chk;

	// set once the first result item has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			seen_q <= 1'b1;
		end
	end

	assign macd_chk = sat(ext(short_ema) - ext(long_ema));
	assign hist_chk = sat(ext(macd_value) - ext(signal_value));

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(histogram) && $stable(short_ema))
		else $error("result item changed while stalled");

	// first result after reset starts the averages at the price
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen_q |-> macd_value == '0 && signal_value == '0 &&
			histogram == '0 && short_ema == long_ema)
		else $error("first result item not seeded");

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// derived fields agree with the averages
	a_derived: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> macd_value == macd_chk && histogram == hist_chk)
		else $error("macd or histogram inconsistent");

endmodule

bind macd_ema_indicator macd_checker u_macd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.short_ema    (out_ch.short_ema),
	.long_ema     (out_ch.long_ema),
	.macd_value   (out_ch.macd_value),
	.signal_value (out_ch.signal_value),
	.histogram    (out_ch.histogram)
);

/* tb/tb_top.sv */
// self-checking testbench for macd_ema_indicator: price items in, ema/macd result items checked
module tb_top;
	import macd_pkg::*;

	localparam int     RESET_CYCLES    = 11;
	localparam int     SETTLE_CYCLES   = 16;
	localparam int     WATCHDOG_CYCLES = 5000;
	localparam int     HOLD_CYCLES     = 400;
	localparam longint DATA_MAX        = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
	localparam longint DATA_MIN        = -DATA_MAX - 1;

	localparam data_t    PRICE_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t    PRICE_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam coef_t    ALPHA_FULL = '1;
	localparam coef_t    ALPHA_ZERO = '0;
	// index with no register behind it
	localparam reg_idx_t REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	macd_in_if  price_ch ();
	macd_out_if res_ch ();
	macd_cfg_if cfg_ch ();

	macd_ema_indicator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (price_ch),
		.out_ch (res_ch),
		.cfg    (cfg_ch)
	);

	// own copy of the block state and alphas
	data_t short_avg_m;
	data_t long_avg_m;
	data_t signal_avg_m;
	bit    seen_price;
	coef_t short_alpha_m;
	coef_t long_alpha_m;
	coef_t signal_alpha_m;

	res_t  ema_due_q[$];
	data_t walk_price;
	bit    src_idle;
	bit    sink_idle;
	int    hold_req;
	int    mismatches;
	int    prices_sent;
	int    results_checked;
	int    reg_writes;
	int    quiet_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// clamp a wide value to the signed data range
	function automatic data_t clamp_data(longint v);
		if (v > DATA_MAX) begin
			return data_t'(DATA_MAX);
		end
		if (v < DATA_MIN) begin
			return data_t'(DATA_MIN);
		end
		return data_t'(v);
	endfunction

	// one ema step, product shifted down with floor rounding
	function automatic data_t ema_next(data_t avg, data_t x, coef_t alpha);
		longint d;
		longint p;
		d = longint'(x) - longint'(avg);
		p = d * longint'({1'b0, alpha});
		return clamp_data(longint'(avg) + (p >>> COEF_WIDTH));
	endfunction

	// advance the averages for one accepted price and queue the result item
	function automatic void update_averages(data_t x);
		res_t r;
		if (!seen_price) begin
			short_avg_m  = x;
			long_avg_m   = x;
			signal_avg_m = '0;
			seen_price   = 1'b1;
			r.macd_value = '0;
			r.histogram  = '0;
		end else begin
			short_avg_m  = ema_next(short_avg_m, x, short_alpha_m);
			long_avg_m   = ema_next(long_avg_m, x, long_alpha_m);
			r.macd_value = clamp_data(longint'(short_avg_m) - longint'(long_avg_m));
			signal_avg_m = ema_next(signal_avg_m, r.macd_value, signal_alpha_m);
			r.histogram  = clamp_data(longint'(r.macd_value) - longint'(signal_avg_m));
		end
		r.short_ema    = short_avg_m;
		r.long_ema     = long_avg_m;
		r.signal_value = signal_avg_m;
		ema_due_q.push_back(r);
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap(bit en);
		int r;
		r = $urandom_range(0, 99);
		if (!en || r < 50) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 30);
	endfunction

	// price source: mostly a random walk, some full-range and extreme values
	function automatic data_t next_price();
		case ($urandom_range(0, 9))
			0: walk_price = data_t'($urandom);
			1: walk_price = $urandom_range(0, 1) ? PRICE_MAX : PRICE_MIN;
			2: walk_price = data_t'($urandom_range(0, 1) ? 0 : -1);
			default: walk_price = walk_price + data_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
		return walk_price;
	endfunction

	function automatic coef_t pick_alpha();
		case ($urandom_range(0, 5))
			0: return ALPHA_ZERO;
			1: return ALPHA_FULL;
			default: return coef_t'($urandom_range(0, 65535));
		endcase
	endfunction

	// send one price item, predict on accept
	task automatic send_price(data_t p);
		int gap;
		gap = pick_gap(src_idle);
		if (gap > 0) begin
			price_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		price_ch.valid <= 1'b1;
		price_ch.price <= p;
		do @(posedge clk); while (!price_ch.ready);
		update_averages(p);
		prices_sent++;
	endtask

	// stop offering prices and let every result drain out
	task automatic wait_idle();
		price_ch.valid <= 1'b0;
		while (ema_due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write, valid left high for the caller
	task automatic write_reg(reg_idx_t idx, coef_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_SHORT_ALPHA:  short_alpha_m  = val;
			REG_LONG_ALPHA:   long_alpha_m   = val;
			REG_SIGNAL_ALPHA: signal_alpha_m = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	// program all three alphas while idle, optionally poke the unused index
	task automatic set_alphas(coef_t s, coef_t l, coef_t g, bit poke_unused);
		wait_idle();
		write_reg(REG_SHORT_ALPHA, s);
		if (poke_unused) begin
			write_reg(REG_UNUSED, coef_t'($urandom));
		end
		write_reg(REG_LONG_ALPHA, l);
		write_reg(REG_SIGNAL_ALPHA, g);
		cfg_ch.valid <= 1'b0;
	endtask

	// first sample and extremes under the reset alphas
	task automatic test_reset_defaults();
		send_price(PRICE_MAX);
		send_price(PRICE_MIN);
		send_price(data_t'(0));
		send_price(data_t'(-1));
		send_price(data_t'(1));
		send_price(PRICE_MAX);
	endtask

	// drive the averages apart so macd and then the histogram clamp
	task automatic test_saturation();
		set_alphas(ALPHA_FULL, ALPHA_FULL, ALPHA_FULL, 1'b0);
		repeat (3) send_price(PRICE_MIN);
		// long held low, short runs high: macd clamps positive
		set_alphas(ALPHA_FULL, ALPHA_ZERO, ALPHA_FULL, 1'b0);
		repeat (3) send_price(PRICE_MAX);
		// signal held high while long catches up
		set_alphas(ALPHA_FULL, ALPHA_FULL, ALPHA_ZERO, 1'b0);
		repeat (3) send_price(PRICE_MAX);
		// short falls, long held high: macd and histogram clamp negative
		set_alphas(ALPHA_FULL, ALPHA_ZERO, ALPHA_ZERO, 1'b1);
		repeat (3) send_price(PRICE_MIN);
	endtask

	// sink holds off for a long stretch while prices keep coming
	task automatic test_backpressure();
		set_alphas(SHORT_ALPHA_RST, LONG_ALPHA_RST, SIGNAL_ALPHA_RST, 1'b0);
		src_idle = 1'b0;
		hold_req = HOLD_CYCLES;
		repeat (40) send_price(next_price());
		src_idle = 1'b1;
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		set_alphas(pick_alpha(), pick_alpha(), pick_alpha(), 1'b1);
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		repeat (80) send_price(next_price());
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	// random alpha settings, each followed by a run of prices
	task automatic test_random_phases(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			set_alphas(pick_alpha(), pick_alpha(), pick_alpha(), 1'($urandom_range(0, 1)));
			src_idle  = (ph % 4) != 3;
			sink_idle = (ph % 3) != 2;
			repeat (per_phase) send_price(next_price());
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	// result sink ready pattern, with an on-request long hold
	initial begin : sink_ready
		int n;
		res_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				res_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(0, 9) < 7 ? $urandom_range(1, 4) : $urandom_range(5, 40))
					@(posedge clk);
				n = pick_gap(sink_idle);
				if (n > 0) begin
					res_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	function automatic void check_field(string name, data_t want, data_t got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// compare each accepted result item with the oldest prediction
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (ema_due_q.size() == 0) begin
				$error("result item with no price outstanding");
				mismatches++;
			end else begin
				want = ema_due_q.pop_front();
				check_field("short_ema", want.short_ema, res_ch.short_ema);
				check_field("long_ema", want.long_ema, res_ch.long_ema);
				check_field("macd_value", want.macd_value, res_ch.macd_value);
				check_field("signal_value", want.signal_value, res_ch.signal_value);
				check_field("histogram", want.histogram, res_ch.histogram);
				results_checked++;
			end
		end
	end

	// stop the run if no channel moves for too long
	always @(posedge clk) begin : watchdog
		if ((price_ch.valid && price_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("timeout after %0d quiet cycles, %0d results outstanding",
				quiet_cycles, ema_due_q.size());
			$display("macd_ema_indicator: mismatch");
			$finish;
		end
	end

	// test sequence
	initial begin
		arst_n         = 1'b0;
		price_ch.valid = 1'b0;
		price_ch.price = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_SHORT_ALPHA;
		cfg_ch.data    = '0;
		short_avg_m    = '0;
		long_avg_m     = '0;
		signal_avg_m   = '0;
		seen_price     = 1'b0;
		short_alpha_m  = SHORT_ALPHA_RST;
		long_alpha_m   = LONG_ALPHA_RST;
		signal_alpha_m = SIGNAL_ALPHA_RST;
		walk_price     = '0;
		src_idle       = 1'b1;
		sink_idle      = 1'b1;
		hold_req       = 0;
		mismatches     = 0;
		prices_sent    = 0;
		results_checked = 0;
		reg_writes     = 0;
		quiet_cycles   = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_saturation();
		test_backpressure();
		test_back_to_back();
		test_random_phases(8, 70);
		wait_idle();

		$display("%0d prices, %0d results checked, %0d register writes",
			prices_sent, results_checked, reg_writes);
		$display("covered first sample, macd and histogram clamping, zero and full alphas, "
			, "unused register index, long output stall");
		if (mismatches == 0 && ema_due_q.size() == 0) begin
			$display("macd_ema_indicator: match");
		end else begin
			$display("macd_ema_indicator: mismatch");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/macd_pkg.sv
rtl/macd_if.sv
rtl/macd_ctrl.sv
rtl/macd_dp.sv
rtl/macd_ema_indicator.sv
rtl/macd_checker.sv
tb/tb_top.sv
